/* rtl/core/atclr_pkg.sv */
`timescale 1ns / 1ps

package atclr_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int COUNT_W    = $clog2(LINE_DEPTH);
    localparam int HEAD_LEN   = 6;
    localparam int TIMEOUT_W  = 20;
    localparam int APB_ADDR_W = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'hFFFFF;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_A     = "A";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_SEMI  = ";";

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] EV_LINE     = 2'd0;
    localparam logic [1:0] EV_OVERFLOW = 2'd1;
    localparam logic [1:0] EV_TIMEOUT  = 2'd2;

    localparam logic [3:0] CMD_SD           = 4'd0;
    localparam logic [3:0] CMD_II           = 4'd1;
    localparam logic [3:0] CMD_GX           = 4'd2;
    localparam logic [3:0] CMD_GY           = 4'd3;
    localparam logic [3:0] CMD_DO           = 4'd4;
    localparam logic [3:0] CMD_DF           = 4'd5;
    localparam logic [3:0] CMD_SC           = 4'd6;
    localparam logic [3:0] CMD_SB           = 4'd7;
    localparam logic [3:0] CMD_SP           = 4'd8;
    localparam logic [3:0] CMD_WP           = 4'd9;
    localparam logic [3:0] CMD_UNRECOGNIZED = 4'd10;

    localparam logic [0:0] REG_IDLE_TIMEOUT = 1'b0;

    typedef logic [7:0] byte_t;

    function automatic logic [3:0] cmd_lookup(input byte_t c0, input byte_t c1);
        logic [3:0] code;
        code = CMD_UNRECOGNIZED;
        unique case ({c0, c1})
            "SD":    code = CMD_SD;
            "II":    code = CMD_II;
            "GX":    code = CMD_GX;
            "GY":    code = CMD_GY;
            "DO":    code = CMD_DO;
            "DF":    code = CMD_DF;
            "SC":    code = CMD_SC;
            "SB":    code = CMD_SB;
            "SP":    code = CMD_SP;
            "WP":    code = CMD_WP;
            default: code = CMD_UNRECOGNIZED;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/at_command_line_receiver_core.sv */
`timescale 1ns / 1ps

// channel   | direction | tdata           | tuser
// s_axis    | in        | [7:0] rx_byte   | [0] op
// m_axis    | out       | [3:0] cmd code  | [1:0] event_kind
// apb       | in        | idle_timeout_ticks at byte address 0
//
// one transaction per cycle sustained while m_axis is not stalled; the path
// from s_axis to m_axis is the input register, then line state update and result register in one pass.
// the line state (head bytes, byte count, idle counter) lives in the second
// stage, so back-to-back items see the state left by the one before.
// reset (rst_n, async) clears the line and loads the timeout with 0xFFFFF.
// a stalled m_axis holds the result; the input register still fills, then
// s_tready drops until the result is taken.

module at_command_line_receiver_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] op

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [3:0] command_code
    output logic [1:0]                          m_tuser,   // [1:0] event_kind

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [atclr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic                               in_valid_reg;
    logic                               in_op_reg;
    atclr_pkg::byte_t                   in_byte_reg;

    logic                               out_valid_reg;
    logic [1:0]                         out_kind_reg;
    logic [3:0]                         out_code_reg;

    logic [atclr_pkg::TIMEOUT_W-1:0]    idle_timeout_reg;
    logic [atclr_pkg::TIMEOUT_W-1:0]    idle_remaining_reg;
    logic [atclr_pkg::TIMEOUT_W-1:0]    idle_remaining_next;
    logic [atclr_pkg::COUNT_W-1:0]      byte_count_reg;
    logic [atclr_pkg::COUNT_W-1:0]      byte_count_next;
    atclr_pkg::byte_t                   head_reg [atclr_pkg::HEAD_LEN];
    atclr_pkg::byte_t                   head_next [atclr_pkg::HEAD_LEN];

    logic                               proc;
    logic                               is_byte;
    logic                               is_lf;
    logic                               res_valid;
    logic [1:0]                         res_kind;
    logic [3:0]                         res_code;
    logic                               clear_line;
    logic                               cfg_write;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_code_reg};
    assign m_tuser  = out_kind_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == atclr_pkg::REG_IDLE_TIMEOUT);
    assign prdata    = (paddr[2] == atclr_pkg::REG_IDLE_TIMEOUT)
                       ? {{(32 - atclr_pkg::TIMEOUT_W){1'b0}}, idle_timeout_reg}
                       : 32'b0;

    assign is_byte = (in_op_reg == atclr_pkg::OP_BYTE);
    assign is_lf   = is_byte && (in_byte_reg == atclr_pkg::CH_LF);

    always_comb
    begin
        res_valid           = 1'b0;
        res_kind            = atclr_pkg::EV_LINE;
        res_code            = 4'd0;
        clear_line          = 1'b0;
        byte_count_next     = byte_count_reg;
        idle_remaining_next = idle_remaining_reg;

        if (is_lf)
        begin
            res_valid  = 1'b1;
            clear_line = 1'b1;
            if (head_reg[0] == atclr_pkg::CH_A && head_reg[1] == atclr_pkg::CH_T
                && head_reg[2] == atclr_pkg::CH_PLUS && head_reg[5] == atclr_pkg::CH_SEMI)
                res_code = atclr_pkg::cmd_lookup(head_reg[3], head_reg[4]);
            else
                res_code = atclr_pkg::CMD_UNRECOGNIZED;
        end
        else if (is_byte)
        begin
            byte_count_next     = byte_count_reg + 1'b1;
            idle_remaining_next = idle_timeout_reg;
            if (byte_count_reg == atclr_pkg::COUNT_W'(atclr_pkg::LINE_DEPTH - 1))
            begin
                res_valid  = 1'b1;
                res_kind   = atclr_pkg::EV_OVERFLOW;
                clear_line = 1'b1;
            end
        end
        else if (byte_count_reg != '0)
        begin
            if (idle_remaining_reg <= atclr_pkg::TIMEOUT_W'(1))
            begin
                res_valid  = 1'b1;
                res_kind   = atclr_pkg::EV_TIMEOUT;
                clear_line = 1'b1;
            end
            else
                idle_remaining_next = idle_remaining_reg - 1'b1;
        end

        if (clear_line)
        begin
            byte_count_next     = '0;
            idle_remaining_next = idle_timeout_reg;
        end

        for (int i = 0; i < atclr_pkg::HEAD_LEN; i++)
        begin
            if (clear_line)
                head_next[i] = '0;
            else if (is_byte && byte_count_reg == atclr_pkg::COUNT_W'(i))
                head_next[i] = in_byte_reg;
            else
                head_next[i] = head_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            idle_timeout_reg   <= atclr_pkg::TIMEOUT_RESET;
            idle_remaining_reg <= atclr_pkg::TIMEOUT_RESET;
            byte_count_reg     <= '0;
            for (int i = 0; i < atclr_pkg::HEAD_LEN; i++)
                head_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
                idle_timeout_reg <= pwdata[atclr_pkg::TIMEOUT_W-1:0];

            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (proc)
            begin
                out_valid_reg      <= res_valid;
                idle_remaining_reg <= idle_remaining_next;
                byte_count_reg     <= byte_count_next;
                for (int i = 0; i < atclr_pkg::HEAD_LEN; i++)
                    head_reg[i] <= head_next[i];
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (proc)
        begin
            out_kind_reg <= res_kind;
            out_code_reg <= res_code;
        end
    end

    a_proc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc && res_valid |=> m_tvalid)
        else $error("result of a processed transaction not presented");

    a_report_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        proc && res_valid |=> byte_count_reg == '0)
        else $error("line not cleared after a report");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    a_error_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != atclr_pkg::EV_LINE |-> m_tdata == 8'd0)
        else $error("error event with nonzero command code");

endmodule
